// ===== hdl/sac_plru_pkg.sv =====
package sac_plru_pkg;

    // Default geometry of the cache.
    localparam int DEF_WAYS       = 8;
    localparam int DEF_SETS       = 64;
    localparam int DEF_LINE_BYTES = 32;

    // Fixed field widths of the streams.
    localparam int ADDR_W    = 32;
    localparam int OUT_WAY_W = 3;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;      // zero one row of the valid and tree memory
        logic rd;       // read the rows of the set addressed by the input
        logic commit;   // write back the rows (the tag row only on a miss) and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // the clearing pass is on its last row
    } sts_t;

endpackage

// ===== hdl/sac_plru_ctrl.sv =====
module sac_plru_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sac_plru_pkg::cmd_t   cmd,
    input  sac_plru_pkg::sts_t   sts
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // An accepted transaction always moves on to the lookup.
    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_LOOKUP))
        else $error("accepted transaction did not enter lookup");

    // A result still waiting is never overwritten by the next lookup.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !cmd.commit)
        else $error("pending result overwritten");

    // Every commit leaves a result on offer.
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("commit did not present a result");

endmodule

// ===== hdl/sac_plru_dp.sv =====
module sac_plru_dp #(
    parameter int WAYS       = sac_plru_pkg::DEF_WAYS,
    parameter int SETS       = sac_plru_pkg::DEF_SETS,
    parameter int LINE_BYTES = sac_plru_pkg::DEF_LINE_BYTES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [sac_plru_pkg::S_TDATA_W-1:0]  s_tdata,
    input  sac_plru_pkg::cmd_t                  cmd,
    output sac_plru_pkg::sts_t                  sts,
    output logic [sac_plru_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int ADDR_W  = sac_plru_pkg::ADDR_W;
    localparam int LINE_SH = $clog2(LINE_BYTES);
    localparam int SET_SH  = $clog2(SETS);
    localparam int SET_W   = (SETS > 1) ? SET_SH : 1;
    localparam int TAG_SH  = LINE_SH + SET_SH;
    localparam int TAG_W   = ADDR_W - TAG_SH;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int TREE_W  = WAYS - 1;
    localparam int NODE_W  = $clog2(2 * WAYS);

    localparam logic [ADDR_W-1:0] LINE_MASK = ~(ADDR_W'(LINE_BYTES) - ADDR_W'(1));
    localparam logic [SET_W-1:0]  SET_MASK  = SET_W'(SETS - 1);

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

    // Heap-ordered tree, node n at bit n-1; 1 sends the victim right.
    function automatic logic [TREE_W-1:0] tree_touch(input logic [TREE_W-1:0] t,
                                                     input logic [WAY_W-1:0]  w);
        logic [NODE_W-1:0] child;
        logic [NODE_W-1:0] node;
        logic [TREE_W-1:0] r;
        r     = t;
        child = NODE_W'(w) + NODE_W'(WAYS);
        node  = child >> 1;
        for (int i = 0; i < NODE_W; i++) begin
            if (node != '0) begin
                for (int k = 0; k < TREE_W; k++) begin
                    if (NODE_W'(k + 1) == node) begin
                        r[k] = !child[0];
                    end
                end
                child = node;
                node  = node >> 1;
            end
        end
        return r;
    endfunction

    // Walk from the root to a victim, flipping each node passed.
    function automatic logic [TREE_W+WAY_W-1:0] tree_victim(input logic [TREE_W-1:0] t);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] v;
        logic [TREE_W-1:0] r;
        logic              b;
        r    = t;
        node = NODE_W'(1);
        for (int i = 0; i < WAY_W; i++) begin
            if (node < NODE_W'(WAYS)) begin
                b = 1'b0;
                for (int k = 0; k < TREE_W; k++) begin
                    if (NODE_W'(k + 1) == node) begin
                        b    = r[k];
                        r[k] = !r[k];
                    end
                end
                node = (node << 1) | NODE_W'(b);
            end
        end
        v = node - NODE_W'(WAYS);
        if (v >= NODE_W'(WAYS)) begin
            v = NODE_W'(WAYS - 1);
        end
        return {r, WAY_W'(v)};
    endfunction

    // Tag memory (contents undefined until written) and valid/tree memory.
    tag_row_t                     tag_mem [SETS];
    logic [TREE_W+WAYS-1:0]       st_mem  [SETS];

    logic [ADDR_W-1:0]            addr_reg;
    logic                         op_reg;
    logic [SET_W-1:0]             set_reg;
    tag_row_t                     tag_row_reg;
    logic [TREE_W+WAYS-1:0]       st_row_reg;
    logic [SET_W-1:0]             clr_cnt_reg;

    logic                         hit_reg;
    logic [sac_plru_pkg::OUT_WAY_W-1:0] way_reg;
    logic [ADDR_W-1:0]            raddr_reg;
    logic                         rwr_reg;

    logic [ADDR_W-1:0]            s_addr;
    logic                         s_op;
    logic [SET_W-1:0]             s_set;
    logic [TAG_W-1:0]             tag_q;
    logic [WAYS-1:0]              valid_cur;
    logic [TREE_W-1:0]            tree_cur;
    logic [WAYS-1:0]              hit_vec;
    logic                         found;
    logic                         full;
    logic [WAY_W-1:0]             hit_way;
    logic [WAY_W-1:0]             inv_way;
    logic [WAY_W-1:0]             way_sel;
    logic [TREE_W+WAY_W-1:0]      vict;
    logic [TREE_W-1:0]            tree_new;
    logic [WAYS-1:0]              valid_new;
    tag_row_t                     tag_row_new;

    assign s_addr = s_tdata[ADDR_W-1:0];
    assign s_op   = s_tdata[ADDR_W];
    assign s_set  = SET_W'(s_addr >> LINE_SH) & SET_MASK;

    assign tag_q     = addr_reg[ADDR_W-1:TAG_SH];
    assign valid_cur = st_row_reg[WAYS-1:0];
    assign tree_cur  = st_row_reg[TREE_W+WAYS-1:WAYS];

    always_comb begin
        hit_way = '0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = valid_cur[w] && (tag_row_reg[w] == tag_q);
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (!valid_cur[w]) begin
                inv_way = WAY_W'(w);
            end
        end
    end

    assign found = |hit_vec;
    assign full  = &valid_cur;
    assign vict  = tree_victim(tree_cur);

    always_comb begin
        priority if (found) begin
            way_sel  = hit_way;
            tree_new = tree_touch(tree_cur, hit_way);
        end else if (!full) begin
            way_sel  = inv_way;
            tree_new = tree_touch(tree_cur, inv_way);
        end else begin
            way_sel  = vict[WAY_W-1:0];
            tree_new = vict[TREE_W+WAY_W-1:WAY_W];
        end
        valid_new   = valid_cur;
        tag_row_new = tag_row_reg;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == way_sel) begin
                valid_new[w]   = 1'b1;
                tag_row_new[w] = tag_q;
            end
        end
    end

    // Memories: read on acceptance; on commit the valid/tree row is written back, and the tag row only on a miss.
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            tag_row_reg <= tag_mem[s_set];
            st_row_reg  <= st_mem[s_set];
            addr_reg    <= s_addr;
            op_reg      <= s_op;
            set_reg     <= s_set;
        end
        if (cmd.clr) begin
            st_mem[clr_cnt_reg] <= '0;
        end else if (cmd.commit) begin
            st_mem[set_reg] <= {tree_new, valid_new};
        end
        if (cmd.commit && !found) begin
            tag_mem[set_reg] <= tag_row_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr) begin
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == SET_W'(SETS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg   <= found;
            way_reg   <= sac_plru_pkg::OUT_WAY_W'(way_sel);
            raddr_reg <= found ? '0 : (addr_reg & LINE_MASK);
            rwr_reg   <= found ? 1'b0 : op_reg;
        end
    end

    assign m_tdata = {3'b000, rwr_reg, raddr_reg, way_reg, hit_reg};

    // Tags in one set stay unique, so at most one way can match.
    a_unique_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $onehot0(hit_vec))
        else $error("several ways hit in one set");

endmodule

// ===== hdl/set_assoc_cache_tree_plru.sv =====
// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tdata: addr[31:0], op[32]
// m_       out        m_tvalid/m_tready   m_tdata: hit[0], way[3:1], refill_addr[35:4],
//                                                  refill_write[36]
//
// Each access reads the set's tag row and valid/tree row from memory, then compares,
// chooses the way and writes back the valid/tree row, and on a miss the tag row.
// After reset a clearing pass zeroes the valid and tree memory, one set per cycle,
// so no transaction is accepted until every set has been cleared.
// A finished result waits in the output register; the next access is accepted
// meanwhile, and only its write-back stalls while the previous result is not taken.
module set_assoc_cache_tree_plru #(
    parameter int WAYS       = sac_plru_pkg::DEF_WAYS,
    parameter int SETS       = sac_plru_pkg::DEF_SETS,
    parameter int LINE_BYTES = sac_plru_pkg::DEF_LINE_BYTES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // addr [31:0], op [32], zero padding [39:33]
    input  logic [sac_plru_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit [0], way [3:1], refill_addr [35:4], refill_write [36], zero padding [39:37]
    output logic [sac_plru_pkg::M_TDATA_W-1:0]  m_tdata
);

    // Commands and status between the sequencing logic and the lookup datapath.
    sac_plru_pkg::cmd_t cmd;
    sac_plru_pkg::sts_t sts;

    // The controller sequences clearing, acceptance and write-back.
    sac_plru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds the memories, the tag compare and the tree logic.
    sac_plru_dp #(
        .WAYS       (WAYS),
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule
